// ===== rtl/text_console_writer_defines.svh =====
// ----------------------------------------------------------------------------
// text_console_writer_defines.svh
// Assertion macros used by the console RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

`ifndef ASSERT_OFF

// concurrent check on an explicit clock and active-low reset
`define TCW_ASSERT_CLK(name, clk_s, rstn_s, prop) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
        else $error("tcw assertion failed");

// concurrent check on the usual clk / rst_n pair
`define TCW_ASSERT(name, prop) \
    `TCW_ASSERT_CLK(name, clk, rst_n, prop)

`else

`define TCW_ASSERT_CLK(name, clk_s, rstn_s, prop)
`define TCW_ASSERT(name, prop)

`endif

`endif

// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and fixed constants of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    // field widths fixed by the interface
    localparam int REQ_W  = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int ATTR_W = 8;
    localparam int DATA_W = 16;
    localparam int ROW_FW = 5;
    localparam int COL_FW = 7;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // special characters and reset values
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_BLANK   = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h5F;

    // command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [CHAR_W-1:0] char_code;
        logic [IDX_W-1:0]  cell_index;
    } tcw_in_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [ROW_FW-1:0] cursor_row;
        logic [COL_FW-1:0] cursor_col;
    } tcw_out_t;

    // decoded operations
    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_TAB,
        OP_READ,
        OP_CLEAR,
        OP_NOP
    } tcw_op_t;

    typedef struct packed {
        tcw_op_t           op;
        logic [CHAR_W-1:0] chr;
        logic              rd_oob;
        logic [ROW_FW-1:0] rd_row;
        logic [COL_FW-1:0] rd_col;
    } tcw_cmd_t;

    // executor states
    typedef enum logic [1:0] {
        BK_RUN,
        BK_READ,
        BK_TAB
    } tcw_state_t;

endpackage

`default_nettype wire

// ===== rtl/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/tcw_front.sv =====
// ----------------------------------------------------------------------------
// tcw_front
// Request intake: classifies the item and splits a read index into row/col.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic    start,
    input  wire tcw_in_t req,
    input  wire logic    q_full,
    output logic         busy,
    output logic         push,
    output tcw_cmd_t     cmd
);

    localparam int CELLS    = ROWS * COLUMNS;
    localparam int RECIP_SH = 20;
    localparam int PROD_W   = IDX_W + RECIP_SH;
    localparam int RECIP    = (2 ** RECIP_SH + COLUMNS - 1) / COLUMNS;

    logic [PROD_W-1:0] prod;
    logic [IDX_W-1:0]  quo;
    logic [IDX_W-1:0]  rem;
    tcw_op_t           op;

    // handshake
    assign busy = q_full;
    assign push = start && !q_full;

    // classify the request
    always_comb
    begin
        unique case (req.req_type)
            REQ_PUT:
            begin
                if (req.char_code == CH_NEWLINE)
                    op = OP_NEWLINE;
                else if (req.char_code == CH_TAB)
                    op = OP_TAB;
                else
                    op = OP_PUT;
            end
            REQ_READ:  op = OP_READ;
            REQ_CLEAR: op = OP_CLEAR;
            default:   op = OP_NOP;
        endcase
    end

    // index / COLUMNS by reciprocal multiplication, exact over the whole index range
    assign prod = PROD_W'(req.cell_index) * PROD_W'(RECIP);
    assign quo  = prod[PROD_W-1:RECIP_SH];
    assign rem  = req.cell_index - quo * IDX_W'(COLUMNS);

    // command to the queue
    always_comb
    begin
        cmd.op     = op;
        cmd.chr    = req.char_code;
        cmd.rd_oob = 32'(req.cell_index) >= 32'(CELLS);
        cmd.rd_row = ROW_FW'(quo);
        cmd.rd_col = COL_FW'(rem);
    end

endmodule

`default_nettype wire

// ===== rtl/tcw_queue.sv =====
// ----------------------------------------------------------------------------
// tcw_queue
// Two-entry command queue between intake and executor.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_queue
    import tcw_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire tcw_cmd_t push_cmd,
    input  wire logic     pop,
    output logic          full,
    output logic          head_valid,
    output tcw_cmd_t      head
);

    tcw_cmd_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tcw_back.sv =====
// ----------------------------------------------------------------------------
// tcw_back
// Executor: cursor, scroll ring, per-row fill tracking and the cell RAM port.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_console_writer_defines.svh"

module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STEP = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [ATTR_W-1:0] attr,
    input  wire logic              head_valid,
    input  wire tcw_cmd_t          head,
    output logic                   pop,
    output logic                   ram_we,
    output logic [$clog2(ROWS*COLUMNS)-1:0] ram_addr,
    output logic [DATA_W-1:0]      ram_wdata,
    input  wire logic [DATA_W-1:0] ram_rdata,
    output logic                   result_valid,
    output tcw_out_t               result
);

    localparam int ROW_W  = $clog2(ROWS);
    localparam int CCW    = $clog2(COLUMNS + 1);
    localparam int CIDX_W = $clog2(COLUMNS);
    localparam int ADDR_W = $clog2(ROWS * COLUMNS);

    tcw_state_t        state_reg, state_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [CCW-1:0]    cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  base_reg, base_next;
    logic [CCW-1:0]    tab_end_reg, tab_end_next;
    logic [ROW_W-1:0]  rd_phys_reg, rd_phys_next;
    logic [CIDX_W-1:0] rd_col_reg, rd_col_next;
    logic [CCW-1:0]    fill_reg [ROWS];
    logic [CCW-1:0]    fill_next [ROWS];
    logic [ATTR_W-1:0] battr_reg [ROWS];
    logic [ATTR_W-1:0] battr_next [ROWS];
    logic              res_valid_reg, res_valid_next;
    tcw_out_t          res_reg, res_next;

    logic [ROW_W-1:0]  cur_phys;
    logic [ROW_W-1:0]  head_phys;
    logic [ROW_W-1:0]  sel_row;
    logic [CCW-1:0]    sel_fill;
    logic [ATTR_W-1:0] sel_battr;
    logic [CCW-1:0]    col_inc;
    logic [CCW:0]      tab_sum;
    logic [CCW-1:0]    tab_end_c;
    logic              col_full;
    logic              at_last;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] head_addr;
    logic              do_nl;
    logic              do_clr;
    logic              finish;
    logic [DATA_W-1:0] rd_data;

    // physical row of a logical row, modulo ROWS
    function automatic logic [ROW_W-1:0] row_add(
        input logic [ROW_W-1:0] a,
        input logic [ROW_W-1:0] b
    );
        logic [ROW_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (ROW_W + 1)'(ROWS))
            s = s - (ROW_W + 1)'(ROWS);
        return s[ROW_W-1:0];
    endfunction

    // addressing and shared lookups
    assign cur_phys  = row_add(base_reg, cur_row_reg);
    assign head_phys = row_add(base_reg, ROW_W'(head.rd_row));
    assign sel_row   = (state_reg == BK_READ) ? rd_phys_reg : cur_phys;
    assign sel_fill  = fill_reg[sel_row];
    assign sel_battr = battr_reg[sel_row];
    assign col_inc   = cur_col_reg + CCW'(1);
    assign col_full  = cur_col_reg >= CCW'(COLUMNS);
    assign at_last   = cur_row_reg == ROW_W'(ROWS - 1);
    assign tab_sum   = {1'b0, cur_col_reg} + (CCW + 1)'(TAB_STEP);
    assign tab_end_c = (tab_sum > (CCW + 1)'(COLUMNS)) ? CCW'(COLUMNS) : tab_sum[CCW-1:0];
    assign cur_addr  = ADDR_W'(cur_phys) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col_reg);
    assign head_addr = ADDR_W'(head_phys) * ADDR_W'(COLUMNS) + ADDR_W'(head.rd_col);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_RUN:
            begin
                if (head_valid && head.op == OP_READ && !head.rd_oob)
                    state_next = BK_READ;
                else if (head_valid && head.op == OP_TAB && !col_full)
                    state_next = BK_TAB;
            end
            BK_READ:
                state_next = BK_RUN;
            BK_TAB:
            begin
                if (col_inc == tab_end_reg)
                    state_next = BK_RUN;
            end
            default:
                state_next = BK_RUN;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        base_next      = base_reg;
        tab_end_next   = tab_end_reg;
        rd_phys_next   = rd_phys_reg;
        rd_col_next    = rd_col_reg;
        fill_next      = fill_reg;
        battr_next     = battr_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_addr       = cur_addr;
        ram_wdata      = {attr, CH_BLANK};
        do_nl          = 1'b0;
        do_clr         = 1'b0;
        finish         = 1'b0;
        rd_data        = '0;

        unique case (state_reg)
            BK_RUN:
            begin
                if (head_valid)
                begin
                    unique case (head.op)
                        OP_PUT:
                        begin
                            // past the last column: wrap first, write next cycle
                            if (col_full)
                                do_nl = 1'b1;
                            else
                            begin
                                ram_we             = 1'b1;
                                ram_wdata          = {attr, head.chr};
                                cur_col_next       = col_inc;
                                fill_next[cur_phys] = col_inc;
                                pop                = 1'b1;
                                finish             = 1'b1;
                            end
                        end
                        OP_NEWLINE:
                        begin
                            do_nl  = 1'b1;
                            pop    = 1'b1;
                            finish = 1'b1;
                        end
                        OP_TAB:
                        begin
                            if (col_full)
                            begin
                                do_nl  = 1'b1;
                                pop    = 1'b1;
                                finish = 1'b1;
                            end
                            else
                                tab_end_next = tab_end_c;
                        end
                        OP_READ:
                        begin
                            if (head.rd_oob)
                            begin
                                pop    = 1'b1;
                                finish = 1'b1;
                            end
                            else
                            begin
                                ram_addr     = head_addr;
                                rd_phys_next = head_phys;
                                rd_col_next  = CIDX_W'(head.rd_col);
                            end
                        end
                        OP_CLEAR:
                        begin
                            do_clr = 1'b1;
                            pop    = 1'b1;
                            finish = 1'b1;
                        end
                        OP_NOP:
                        begin
                            pop    = 1'b1;
                            finish = 1'b1;
                        end
                        default:
                        begin
                            pop    = 1'b1;
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            BK_READ:
            begin
                // cells at or past the row's fill count still hold the row blank
                if (CCW'(rd_col_reg) < sel_fill)
                    rd_data = ram_rdata;
                else
                    rd_data = {sel_battr, CH_BLANK};
                pop    = 1'b1;
                finish = 1'b1;
            end
            BK_TAB:
            begin
                // blank the skipped cells one per cycle to keep the row dense
                ram_we              = 1'b1;
                ram_wdata           = {sel_battr, CH_BLANK};
                cur_col_next        = col_inc;
                fill_next[cur_phys] = col_inc;
                if (col_inc == tab_end_reg)
                begin
                    pop    = 1'b1;
                    finish = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // advance to the next row, scrolling the ring at the bottom
        if (do_nl)
        begin
            cur_col_next = '0;
            if (at_last)
            begin
                base_next             = row_add(base_reg, ROW_W'(1));
                fill_next[base_reg]   = '0;
                battr_next[base_reg]  = attr;
            end
            else
                cur_row_next = cur_row_reg + ROW_W'(1);
        end

        // clear screen: every row blank with the current attribute
        if (do_clr)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                fill_next[i]  = '0;
                battr_next[i] = attr;
            end
            base_next    = '0;
            cur_row_next = '0;
            cur_col_next = '0;
        end

        // result
        if (finish)
        begin
            res_valid_next      = 1'b1;
            res_next.read_data  = rd_data;
            res_next.cursor_row = ROW_FW'(cur_row_next);
            res_next.cursor_col = COL_FW'(cur_col_next);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_RUN;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            base_reg      <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < ROWS; i++)
            begin
                fill_reg[i]  <= '0;
                battr_reg[i] <= ATTR_RESET;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            base_reg      <= base_next;
            res_valid_reg <= res_valid_next;
            fill_reg      <= fill_next;
            battr_reg     <= battr_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        tab_end_reg <= tab_end_next;
        rd_phys_reg <= rd_phys_next;
        rd_col_reg  <= rd_col_next;
        res_reg     <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // checks
    `TCW_ASSERT(a_read_follows_issue, state_reg == BK_READ |-> $past(state_reg) == BK_RUN)
    `TCW_ASSERT(a_result_after_pop, res_valid_reg |-> $past(pop))
    `TCW_ASSERT(a_cursor_row_dense, fill_reg[cur_phys] == cur_col_reg)

endmodule

`default_nettype wire

// ===== rtl/text_console_writer.sv =====
// Text console writer: cell store with cursor, scroll ring and read-back.
// Flow: a request is queued, run from the queue head and its result strobe registered;
//   in-range reads also pass the RAM read and BK_READ, tabs blank cells in BK_TAB.
// Throughput: one put per cycle while no wrapping put, read or tab holds the executor.
//   Two-entry queue, busy while full; results are never stalled.
// Reset: all cells read as blank 0x5F20 at once via per-row fill counts.
// ----------------------------------------------------------------------------
// text_console_writer
// Top level: configuration register, intake, command queue, executor, RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STEP = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire tcw_in_t           req,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [ATTR_W-1:0] cfg_data,
    output logic                   result_valid,
    output tcw_out_t               result
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);

    logic [ATTR_W-1:0] attr_reg;
    logic              q_full;
    logic              push;
    tcw_cmd_t          push_cmd;
    logic              pop;
    logic              head_valid;
    tcw_cmd_t          head;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;

    // attribute register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            attr_reg <= ATTR_RESET;
        else if (cfg_valid && cfg_ready)
            attr_reg <= cfg_data;
    end

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .start  (start),
        .req    (req),
        .q_full (q_full),
        .busy   (busy),
        .push   (push),
        .cmd    (push_cmd)
    );

    tcw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    tcw_back #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STEP (TAB_STEP)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .attr         (attr_reg),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .ram_we       (ram_we),
        .ram_addr     (ram_addr),
        .ram_wdata    (ram_wdata),
        .ram_rdata    (ram_rdata),
        .result_valid (result_valid),
        .result       (result)
    );

    tcw_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire
